// ----- sv/prs80_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package prs80_pkg;

  // Widths fixed by the cipher, and those of the configuration channel.
  localparam int BLOCK_W      = 64;
  localparam int KEY_W        = 80;
  localparam int KEY_UPPER_W  = 16;
  localparam int ROUND_IDX_W  = 5;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 64;

  // Full PRESENT-80 round count.
  localparam int ROUND_COUNT_DEF = 31;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_UPPER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOWER = 2'd1;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;

  // The 4-bit PRESENT S-box.
  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // S-box applied to all sixteen nibbles.
  function automatic block_t nibble_sub_layer(input block_t s);
    block_t r;
    r = '0;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      r[4*n +: 4] = sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

  // Bit permutation: bit i moves to 16*i mod 63, bit 63 stays. Pure wiring.
  function automatic block_t perm_layer(input block_t s);
    block_t r;
    r = '0;
    for (int i = 0; i < BLOCK_W - 1; i++) begin
      r[(16 * i) % 63] = s[i];
    end
    r[BLOCK_W-1] = s[BLOCK_W-1];
    return r;
  endfunction

  // Round key is the top 64 bits of the key register.
  function automatic block_t round_key(input key_t k);
    return k[KEY_W-1 -: BLOCK_W];
  endfunction

endpackage

`default_nettype wire

// ----- sv/prs80_round.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One cipher round together with the key register update that follows it.
module prs80_round (
  input  wire prs80_pkg::block_t                        state_in,
  input  wire prs80_pkg::key_t                          key_in,
  input  wire logic [prs80_pkg::ROUND_IDX_W-1:0]        round_num,
  output prs80_pkg::block_t                             state_out,
  output prs80_pkg::key_t                               key_out
);

  prs80_pkg::key_t key_rot;

  // Add round key, substitute, permute.
  assign state_out = prs80_pkg::perm_layer(
      prs80_pkg::nibble_sub_layer(state_in ^ prs80_pkg::round_key(key_in)));

  // Rotate left by 61, S-box on the top nibble, counter into bits 19..15.
  assign key_rot = {key_in[18:0], key_in[79:19]};

  always_comb begin
    key_out        = key_rot;
    key_out[79:76] = prs80_pkg::sbox(key_rot[79:76]);
    key_out[19:15] = key_rot[19:15] ^ round_num;
  end

endmodule

`default_nettype wire

// ----- sv/present80_block_encrypt_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A word accepted at the input passes each round stage, then the output register.
// Throughput: one word per cycle unless the output stalls; each round has its own
// pipeline stage and the final key XOR sits in the output register.
// Stages with no valid word fill while the output is stalled.
// Reset (synchronous, rst_n low) clears all valid bits and both key registers.
module present80_block_encrypt_unit #(
  parameter int ROUND_COUNT = prs80_pkg::ROUND_COUNT_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Configuration write channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [prs80_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [prs80_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Plaintext channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [63:0]                           in_plaintext,
  // Ciphertext channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [63:0]                                out_ciphertext
);

  logic [prs80_pkg::KEY_UPPER_W-1:0] key_upper_r;
  logic [prs80_pkg::BLOCK_W-1:0]     key_lower_r;

  prs80_pkg::block_t st_r  [ROUND_COUNT];
  prs80_pkg::key_t   key_r [ROUND_COUNT];
  logic [ROUND_COUNT-1:0] vld_r;

  prs80_pkg::block_t st_nxt  [ROUND_COUNT];
  prs80_pkg::key_t   key_nxt [ROUND_COUNT];
  logic [ROUND_COUNT-1:0] vld_in;
  logic [ROUND_COUNT:0]   ready;

  logic              out_valid_r;
  prs80_pkg::block_t out_data_r;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        prs80_pkg::REG_KEY_UPPER: key_upper_r <= cfg_data[prs80_pkg::KEY_UPPER_W-1:0];
        prs80_pkg::REG_KEY_LOWER: key_lower_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its word moves on.
  assign ready[ROUND_COUNT] = !out_valid_r || !out_stall;
  assign in_stall           = !ready[0];

  genvar gi;
  generate
    for (gi = 0; gi < ROUND_COUNT; gi++) begin : g_stage
      localparam logic [prs80_pkg::ROUND_IDX_W-1:0] RNUM =
        prs80_pkg::ROUND_IDX_W'(gi + 1);

      assign ready[gi] = !vld_r[gi] || ready[gi+1];

      if (gi == 0) begin : g_first
        assign vld_in[gi] = in_valid;
        prs80_round u_round (
          .state_in  (in_plaintext),
          .key_in    ({key_upper_r, key_lower_r}),
          .round_num (RNUM),
          .state_out (st_nxt[gi]),
          .key_out   (key_nxt[gi])
        );
      end else begin : g_next
        assign vld_in[gi] = vld_r[gi-1];
        prs80_round u_round (
          .state_in  (st_r[gi-1]),
          .key_in    (key_r[gi-1]),
          .round_num (RNUM),
          .state_out (st_nxt[gi]),
          .key_out   (key_nxt[gi])
        );
      end

      // Stage valid bit.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[gi] <= 1'b0;
        end else if (ready[gi]) begin
          vld_r[gi] <= vld_in[gi];
        end
      end

      // Stage payload: block state and key register.
      always_ff @(posedge clk) begin
        if (ready[gi] && vld_in[gi]) begin
          st_r[gi]  <= st_nxt[gi];
          key_r[gi] <= key_nxt[gi];
        end
      end
    end
  endgenerate

  // Output register with the final round-key XOR.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready[ROUND_COUNT]) begin
      out_valid_r <= vld_r[ROUND_COUNT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ready[ROUND_COUNT] && vld_r[ROUND_COUNT-1]) begin
      out_data_r <= st_r[ROUND_COUNT-1] ^ prs80_pkg::round_key(key_r[ROUND_COUNT-1]);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ciphertext = out_data_r;

endmodule

`default_nettype wire

// ----- sv/present80_block_encrypt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module present80_block_encrypt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_ciphertext
);

  // A stalled result word stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result word keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_ciphertext))
    else $error("out_ciphertext changed while stalled");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // The input only stalls when a result waits behind a stalled output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a blocked output");

endmodule

bind present80_block_encrypt_unit present80_block_encrypt_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ciphertext (out_ciphertext)
);

`default_nettype wire

// ----- dv/present80_ciphertext_checker.sv -----
`timescale 1ns / 1ps

// Watches the key, plaintext and ciphertext channels of the PRESENT-80 unit.
// It keeps its own copy of the 80-bit key, encrypts each accepted plaintext
// word and compares every accepted ciphertext word with the oldest prediction.
module present80_ciphertext_checker #(
  parameter int ROUNDS = prs80_pkg::ROUND_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [prs80_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [prs80_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  prs80_pkg::block_t                 in_plaintext,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  prs80_pkg::block_t                 out_ciphertext,
  output int                                mismatch_count,
  output int                                words_pending,
  output int                                words_checked
);

  // S-box outputs packed by input nibble, entry 0 in the lowest nibble.
  localparam logic [63:0] SBOX_NIBBLES = 64'h2174_8FE3_DA09_B65C;
  localparam int          REPORT_LIMIT = 10;

  prs80_pkg::key_t   cipher_key;
  prs80_pkg::block_t ciphertext_q[$];
  prs80_pkg::block_t plaintext_q[$];
  prs80_pkg::block_t want_ct;
  prs80_pkg::block_t sent_pt;
  int                fail_total;
  int                good_total;

  function automatic logic [3:0] sub_nibble(input logic [3:0] x);
    return SBOX_NIBBLES[4*x +: 4];
  endfunction

  // Full PRESENT encryption of one block under an 80-bit key.
  function automatic prs80_pkg::block_t encrypt_block(input prs80_pkg::block_t plain,
                                                      input prs80_pkg::key_t key);
    prs80_pkg::block_t st;
    prs80_pkg::block_t mixed;
    prs80_pkg::key_t   k;
    st = plain;
    k  = key;
    for (int r = 1; r <= ROUNDS; r++) begin
      // Round key mix, then substitution of all sixteen nibbles.
      mixed = st ^ k[79:16];
      for (int n = 0; n < 16; n++) begin
        st[4*n +: 4] = sub_nibble(mixed[4*n +: 4]);
      end
      // Bit i moves to 16*i mod 63; the top bit stays where it is.
      mixed = st;
      for (int b = 0; b < 63; b++) begin
        st[(16 * b) % 63] = mixed[b];
      end
      st[63] = mixed[63];
      // Key update: rotate left by 61, S-box on the top nibble, add the counter.
      k = {k[18:0], k[79:19]};
      k[79:76] = sub_nibble(k[79:76]);
      k[19:15] = k[19:15] ^ r[4:0];
    end
    return st ^ k[79:16];
  endfunction

  // All channels are sampled at the rising edge, before the edge's updates land.
  always @(posedge clk) begin
    if (!rst_n) begin
      cipher_key = '0;
      ciphertext_q.delete();
      plaintext_q.delete();
      fail_total = 0;
      good_total = 0;
    end else begin
      // A plaintext word uses the key that holds before this edge.
      if (in_valid && !in_stall) begin
        ciphertext_q.push_back(encrypt_block(in_plaintext, cipher_key));
        plaintext_q.push_back(in_plaintext);
      end

      // Compare a delivered ciphertext word with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (ciphertext_q.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT) begin
            $display("[%0t] unexpected ciphertext word %h", $realtime, out_ciphertext);
          end
        end else begin
          want_ct = ciphertext_q.pop_front();
          sent_pt = plaintext_q.pop_front();
          if (out_ciphertext !== want_ct) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT) begin
              $display("[%0t] ciphertext mismatch for plaintext %h: expected %h, got %h",
                       $realtime, sent_pt, want_ct, out_ciphertext);
            end
          end else begin
            good_total++;
          end
        end
      end

      // Key register writes; indexes outside the register map are dropped.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == prs80_pkg::REG_KEY_UPPER) begin
          cipher_key[79:64] = cfg_data[15:0];
        end else if (cfg_index == prs80_pkg::REG_KEY_LOWER) begin
          cipher_key[63:0] = cfg_data;
        end
      end
    end
    mismatch_count <= fail_total;
    words_checked  <= good_total;
    words_pending  <= ciphertext_q.size();
  end

endmodule

// ----- dv/present80_block_encrypt_unit_tb.sv -----
`timescale 1ns / 1ps

module present80_block_encrypt_unit_tb;

  localparam int CLK_PERIOD      = 10;
  localparam int ROUNDS          = prs80_pkg::ROUND_COUNT_DEF;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 192;
  localparam int TIMEOUT_CYCLES  = 200000;

  // Indexes with no register behind them.
  localparam logic [prs80_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [prs80_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                              clk          = 1'b0;
  logic                              rst_n        = 1'b0;
  logic                              cfg_valid    = 1'b0;
  logic                              cfg_ready;
  logic [prs80_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [prs80_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                              in_valid     = 1'b0;
  logic                              in_stall;
  prs80_pkg::block_t                 in_plaintext = '0;
  logic                              out_valid;
  logic                              out_stall    = 1'b0;
  prs80_pkg::block_t                 out_ciphertext;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int key_settings   = 0;
  int mismatch_count;
  int words_pending;
  int words_checked;

  present80_block_encrypt_unit #(
    .ROUND_COUNT(ROUNDS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_plaintext  (in_plaintext),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ciphertext(out_ciphertext)
  );

  present80_ciphertext_checker #(
    .ROUNDS(ROUNDS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_plaintext  (in_plaintext),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ciphertext(out_ciphertext),
    .mismatch_count(mismatch_count),
    .words_pending (words_pending),
    .words_checked (words_checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Drives one configuration register write and holds it until the unit takes it.
  task automatic write_reg(input logic [prs80_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [prs80_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Loads a full 80-bit key in random register order; upper data carries junk
  // above bit 15.
  task automatic load_key(input prs80_pkg::key_t k);
    logic [prs80_pkg::CFG_DATA_W-1:0] upper_word;
    upper_word = {$urandom, 16'($urandom), k[79:64]};
    if ($urandom_range(1) == 0) begin
      write_reg(prs80_pkg::REG_KEY_UPPER, upper_word);
      write_reg(prs80_pkg::REG_KEY_LOWER, k[63:0]);
    end else begin
      write_reg(prs80_pkg::REG_KEY_LOWER, k[63:0]);
      write_reg(prs80_pkg::REG_KEY_UPPER, upper_word);
    end
    cfg_valid <= 1'b0;
    key_settings++;
  endtask

  // Offers one plaintext word after a random gap and waits for acceptance.
  task automatic push_block(input prs80_pkg::block_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_plaintext <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted word has come out.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  function automatic prs80_pkg::block_t corner_plaintext(input int sel);
    case (sel)
      0:       return 64'h0;
      1:       return 64'hFFFF_FFFF_FFFF_FFFF;
      2:       return 64'h0123_4567_89AB_CDEF;
      3:       return 64'h8000_0000_0000_0000;
      default: return 64'h1;
    endcase
  endfunction

  // Mostly dense random words, with some single-bit, single-hole and flat words.
  function automatic prs80_pkg::block_t pick_plaintext();
    int                sel;
    prs80_pkg::block_t pt;
    sel = $urandom_range(9);
    pt  = {$urandom, $urandom};
    case (sel)
      0:       pt = 64'h1 << $urandom_range(63);
      1:       pt = ~(64'h1 << $urandom_range(63));
      2:       pt = ($urandom_range(1) == 0) ? 64'h0 : 64'hFFFF_FFFF_FFFF_FFFF;
      default: ;
    endcase
    return pt;
  endfunction

  function automatic prs80_pkg::key_t pick_key();
    prs80_pkg::key_t k;
    k[79:64] = 16'($urandom);
    k[63:32] = $urandom;
    k[31:0]  = $urandom;
    if ($urandom_range(7) == 0) begin
      k = '1 ^ ((80'h1) << $urandom_range(79));
    end
    return k;
  endfunction

  // Main sequence: reset, directed corners, then random phases under each idling mix.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key of all zeros.
    for (int i = 0; i < 5; i++) push_block(corner_plaintext(i));
    drain_pipeline();

    // Key of all ones.
    load_key('1);
    for (int i = 0; i < 5; i++) push_block(corner_plaintext(i));
    drain_pipeline();

    // Writes to unmapped indexes must leave the key alone.
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, 64'h0);
    cfg_valid <= 1'b0;
    push_block(corner_plaintext(0));
    push_block(corner_plaintext(2));
    drain_pipeline();

    // Single key bits at both ends of the key register.
    load_key({16'h8000, 64'h1});
    push_block(corner_plaintext(0));
    push_block(corner_plaintext(1));
    drain_pipeline();

    // Random phases, cycling through the idling mixes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      // An unmapped write goes straight into the key load, which ends the burst.
      if ($urandom_range(2) == 0) begin
        write_reg(($urandom_range(1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
      end
      load_key(pick_key());
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Once, the sender holds off mid-phase until the pipeline is empty.
        if (p == 5 && n == WORDS_PER_PHASE / 2) drain_pipeline();
        push_block(pick_plaintext());
      end
      drain_pipeline();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_pipeline();
    repeat (ROUNDS + 8) @(posedge clk);

    $display("Checked %0d ciphertext words under %0d loaded keys, with sender gaps",
             words_checked, key_settings);
    $display("and receiver stalls from none up to 58 percent of cycles.");
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timed out with %0d ciphertext words outstanding.", words_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- present80_block_encrypt_unit.f -----
sv/prs80_pkg.sv
sv/prs80_round.sv
sv/present80_block_encrypt_unit.sv
sv/present80_block_encrypt_checker.sv
dv/present80_ciphertext_checker.sv
dv/present80_block_encrypt_unit_tb.sv
